### rtl/assert_macros.svh
// assertion helpers for the peak meter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked outside reset
`define APM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, checked outside reset
`define APM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define APM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define APM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/apm_pkg.sv
`timescale 1ns / 1ps
package apm_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MAG_W    = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME_MS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_DROP_STEP = 1'b1;

  localparam logic [CFG_W-1:0] RESET_HOLD_TIME_MS   = 16'd1000;
  localparam logic [CFG_W-1:0] RESET_HOLD_DROP_STEP = 16'd500;

  // largest magnitude a sample can have
  localparam logic [MAG_W-1:0] MAG_MAX = 16'h8000;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [MAG_W-1:0]    mag_t;
  typedef logic [TIME_W-1:0]   time_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_W-1:0]    cfg_data_t;

  typedef struct packed {
    sample_t sample;
    logic    last;
    time_t   time_ms;
  } in_item_t;

  // |x| of a two's complement sample, -32768 gives 32768
  function automatic mag_t magnitude(input sample_t s);
    mag_t m;
    m = s[SAMPLE_W-1] ? mag_t'(~s + sample_t'(1)) : mag_t'(s);
    return m;
  endfunction

  // floor(v * 7 / 8)
  function automatic mag_t decay_7_8(input mag_t v);
    logic [MAG_W+2:0] prod;
    prod = ({3'b000, v} << 3) - {3'b000, v};
    return prod[MAG_W+2:3];
  endfunction

endpackage

### rtl/audio_peak_meter_with_hold.sv
`timescale 1ns / 1ps
// audio peak meter with decay and peak hold
//
// in channel: one signed 16-bit sample per item, with a last-of-block flag
// and a millisecond time stamp, moved by in_valid / in_ready
// out channel: one item per block end carrying the peak level and the
// peak hold after that block's update, moved by out_valid / out_ready
// cfg port: cfg_wr_en writes cfg_wdata into register cfg_index at once;
// index 0 is the hold time in ms, index 1 the hold drop step
//
// an item waits in the input register, then the block max, level and
// hold update and a block end's result lands in the output register
// throughput is one item per cycle while no block end waits on the output
// register, set by the single update stage
// while the output register holds a result that is not taken, an item
// that does not end a block still moves on; a block end waits in the input
// register and in_ready drops until the output register frees up
// reset clears the block max, level, hold and time stamp, empties both
// registers and loads the hold time with 1000 and the drop step with 500
module audio_peak_meter_with_hold (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  apm_pkg::sample_t     in_sample,
  input  logic                 in_last_in_block,
  input  apm_pkg::time_t       in_time_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output apm_pkg::mag_t        out_level_out,
  output apm_pkg::mag_t        out_hold_out,
  input  logic                 cfg_wr_en,
  input  apm_pkg::cfg_idx_t    cfg_index,
  input  apm_pkg::cfg_data_t   cfg_wdata
);
  import apm_pkg::*;
  `include "assert_macros.svh"

  // configuration
  cfg_data_t hold_time_r;
  cfg_data_t drop_step_r;

  // input register
  logic     s1_valid_r;
  in_item_t s1_item_r;

  // meter state
  mag_t  block_max_r, block_max_nxt;
  mag_t  level_r, level_nxt;
  mag_t  hold_r, hold_nxt;
  time_t stamp_r, stamp_nxt;

  // output register
  logic out_valid_r;
  mag_t out_level_r, out_hold_r;

  logic  out_free;
  logic  advance;
  logic  adv_last;
  mag_t  mag;
  mag_t  blk_m;
  time_t elapsed;
  logic  hold_expired;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_time_r <= RESET_HOLD_TIME_MS;
      drop_step_r <= RESET_HOLD_DROP_STEP;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_HOLD_TIME_MS:   hold_time_r <= cfg_wdata;
        REG_HOLD_DROP_STEP: drop_step_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a block end needs room in the output register, other items never wait
  assign out_free = !out_valid_r || out_ready;
  assign advance  = s1_valid_r && (!s1_item_r.last || out_free);
  assign adv_last = advance && s1_item_r.last;
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r.sample  <= in_sample;
      s1_item_r.last    <= in_last_in_block;
      s1_item_r.time_ms <= in_time_ms;
    end
  end

  // update for the item in the input register
  always_comb begin
    mag          = magnitude(s1_item_r.sample);
    blk_m        = (mag > block_max_r) ? mag : block_max_r;
    elapsed      = s1_item_r.time_ms - stamp_r;
    hold_expired = elapsed > {{(TIME_W-CFG_W){1'b0}}, hold_time_r};

    block_max_nxt = block_max_r;
    level_nxt     = level_r;
    hold_nxt      = hold_r;
    stamp_nxt     = stamp_r;

    if (advance) begin
      block_max_nxt = s1_item_r.last ? '0 : blk_m;
      if (s1_item_r.last) begin
        // fast attack, 7/8 decay
        level_nxt = (blk_m > level_r) ? blk_m : decay_7_8(level_r);
        if (blk_m > hold_r) begin
          hold_nxt  = blk_m;
          stamp_nxt = s1_item_r.time_ms;
        end else if (hold_expired) begin
          // drop saturates at zero
          hold_nxt = (hold_r > drop_step_r) ? hold_r - drop_step_r : '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_max_r <= '0;
      level_r     <= '0;
      hold_r      <= '0;
      stamp_r     <= '0;
    end else begin
      block_max_r <= block_max_nxt;
      level_r     <= level_nxt;
      hold_r      <= hold_nxt;
      stamp_r     <= stamp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_last) begin
      out_level_r <= level_nxt;
      out_hold_r  <= hold_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_level_out = out_level_r;
  assign out_hold_out  = out_hold_r;

  `APM_ASSERT_NEXT(a_blk_clear, clk, rst_n, adv_last, block_max_r == '0)
  `APM_ASSERT_IMPL(a_res_src, clk, rst_n, $rose(out_valid_r), $past(adv_last))
  `APM_ASSERT_IMPL(a_no_overrun, clk, rst_n, adv_last, out_free)
  `APM_ASSERT_IMPL(a_range, clk, rst_n, 1'b1, (level_r <= MAG_MAX) && (hold_r <= MAG_MAX))

endmodule

### verif/peak_meter_checker.sv
`timescale 1ns / 1ps
module peak_meter_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  apm_pkg::sample_t    in_sample,
  input  logic                in_last_in_block,
  input  apm_pkg::time_t      in_time_ms,
  input  logic                out_valid,
  input  logic                out_ready,
  input  apm_pkg::mag_t       out_level_out,
  input  apm_pkg::mag_t       out_hold_out,
  input  logic                cfg_wr_en,
  input  apm_pkg::cfg_idx_t   cfg_index,
  input  apm_pkg::cfg_data_t  cfg_wdata,
  output int unsigned         mismatches,
  output int unsigned         readings_due
);
  import apm_pkg::*;

  localparam int unsigned DECAY_NUM = 7;
  localparam int unsigned DECAY_DEN = 8;

  typedef struct packed {
    mag_t level;
    mag_t hold;
  } reading_t;

  reading_t    readings_q[$];
  int unsigned fails = 0;

  // copy of the meter state and its registers
  cfg_data_t hold_time;
  cfg_data_t drop_step;
  mag_t      cur_max;
  mag_t      level;
  mag_t      hold;
  time_t     stamp;

  assign mismatches = fails;

  // folds one sample into the meter; returns 1 with the reading at a block end
  function automatic bit take_sample(input sample_t s, input logic last, input time_t now,
                                     output reading_t r);
    int   sv;
    mag_t mag;
    mag_t m;
    sv  = $signed(s);
    mag = mag_t'(sv < 0 ? -sv : sv);
    r   = '0;
    if (mag > cur_max) cur_max = mag;
    if (!last) return 1'b0;
    m       = cur_max;
    cur_max = '0;
    if (m > level) level = m;
    else level = mag_t'((32'(level) * DECAY_NUM) / DECAY_DEN);
    if (m > hold) begin
      hold  = m;
      stamp = now;
    end else if (time_t'(now - stamp) > 32'(hold_time)) begin
      hold = (hold > drop_step) ? mag_t'(hold - drop_step) : '0;
    end
    r.level = level;
    r.hold  = hold;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    reading_t got;
    reading_t want;
    reading_t r;
    if (!rst_n) begin
      hold_time = RESET_HOLD_TIME_MS;
      drop_step = RESET_HOLD_DROP_STEP;
      cur_max   = '0;
      level     = '0;
      hold      = '0;
      stamp     = '0;
      readings_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_HOLD_TIME_MS:   hold_time = cfg_wdata;
          REG_HOLD_DROP_STEP: drop_step = cfg_wdata;
          default: ;
        endcase
      end
      // results leave before this edge's item is folded in
      if (out_valid && out_ready) begin
        got.level = out_level_out;
        got.hold  = out_hold_out;
        if (readings_q.size() == 0) begin
          fails++;
          $error("unexpected reading: level_out %0d, hold_out %0d", got.level, got.hold);
        end else begin
          want = readings_q.pop_front();
          if (got.level !== want.level) begin
            fails++;
            $error("level_out: expected %0d, got %0d", want.level, got.level);
          end
          if (got.hold !== want.hold) begin
            fails++;
            $error("hold_out: expected %0d, got %0d", want.hold, got.hold);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (take_sample(in_sample, in_last_in_block, in_time_ms, r)) readings_q.push_back(r);
      end
    end
    readings_due <= readings_q.size();
  end

endmodule

### verif/tb_audio_peak_meter_with_hold.sv
`timescale 1ns / 1ps
module tb_audio_peak_meter_with_hold;
  import apm_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1900;
  // watchdog: cycles in a row with no item moving on either channel
  localparam int unsigned STALL_LIMIT  = 3000;
  // length of the deliberate receiver hold-off
  localparam int unsigned LONG_STALL   = 80;

  logic      clk              = 1'b0;
  logic      rst_n            = 1'b0;
  logic      in_valid         = 1'b0;
  logic      in_ready;
  sample_t   in_sample        = '0;
  logic      in_last_in_block = 1'b0;
  time_t     in_time_ms       = '0;
  logic      out_valid;
  logic      out_ready        = 1'b0;
  mag_t      out_level_out;
  mag_t      out_hold_out;
  logic      cfg_wr_en        = 1'b0;
  cfg_idx_t  cfg_index        = REG_HOLD_TIME_MS;
  cfg_data_t cfg_wdata        = '0;

  // idle odds in percent per cycle for each side
  int unsigned send_idle_pct  = 38;
  int unsigned recv_idle_pct  = 55;
  bit          long_stall_req = 1'b0;
  int unsigned idle_cycles    = 0;
  int unsigned items_sent     = 0;
  // running millisecond clock handed out as item time stamps
  time_t       clock_ms       = '0;
  int unsigned mismatches;
  int unsigned readings_due;

  // hold time and drop step for each random segment, extremes included
  cfg_data_t seg_hold [6] = '{16'd300, 16'd0, 16'd2000, 16'hFFFF, 16'd1, 16'd600};
  cfg_data_t seg_step [6] = '{16'd1000, 16'h8000, 16'd250, 16'hFFFF, 16'd0, 16'd7};

  always #6 clk = ~clk;

  audio_peak_meter_with_hold dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .in_last_in_block (in_last_in_block),
    .in_time_ms       (in_time_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_level_out    (out_level_out),
    .out_hold_out     (out_hold_out),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  peak_meter_checker meter_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .in_last_in_block (in_last_in_block),
    .in_time_ms       (in_time_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_level_out    (out_level_out),
    .out_hold_out     (out_hold_out),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .mismatches       (mismatches),
    .readings_due     (readings_due)
  );

  // offers one sample item after a random gap and returns at the edge
  // where it is accepted
  task automatic offer(input sample_t s, input logic last, input time_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_sample        <= s;
    in_last_in_block <= last;
    in_time_ms       <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stops sending, waits for every reading still owed, then lets trailing
  // non-final samples drain through the two-stage pipe
  task automatic settle(input int unsigned tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (readings_due != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // register writes only ever happen with the meter idle
  task automatic set_meter(input cfg_data_t hold_ms, input cfg_data_t step);
    settle(4);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_HOLD_TIME_MS;
    cfg_wdata <= hold_ms;
    @(posedge clk);
    cfg_index <= REG_HOLD_DROP_STEP;
    cfg_wdata <= step;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // one block of samples with a random loudness; time mostly creeps forward,
  // now and then it jumps ahead or lands anywhere (including backwards)
  task automatic send_block(input int unsigned len);
    int unsigned amp;
    sample_t     s;
    amp = $urandom_range(32768) >> $urandom_range(7);
    if ($urandom_range(19) == 0) clock_ms += $urandom_range(3000);
    else if ($urandom_range(59) == 0) clock_ms = $urandom();
    for (int unsigned k = 0; k < len; k++) begin
      clock_ms += $urandom_range(15);
      if ($urandom_range(7) == 0) s = sample_t'($urandom());
      else s = sample_t'(int'($urandom_range(2 * amp)) - int'(amp));
      offer(s, k == len - 1, clock_ms);
    end
    items_sent += len;
  endtask

  // receiver: random ready, plus one long hold-off on request that it
  // times on its own
  initial begin
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        out_ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        long_stall_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: nothing moving for too long ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned target;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed, with the reset register values: hold time 1000, step 500
    // full-scale negative sample alone in its block sets level and hold
    offer(16'h8000, 1'b1, 32'd0);
    // smaller block max: level decays, hold still within its time
    offer(16'h7FFF, 1'b0, 32'd4);
    offer(16'h0000, 1'b0, 32'd6);
    offer(16'hFFFF, 1'b0, 32'd8);
    offer(16'h0001, 1'b1, 32'd10);
    // elapsed exactly equal to the hold time: no drop yet
    offer(16'h0001, 1'b1, 32'd1000);
    // one past the hold time: hold drops by the step
    offer(16'h0000, 1'b1, 32'd1001);
    // time runs back, still within the hold time of the stamp: no drop
    offer(16'h0005, 1'b1, 32'd500);
    // new hold just before the counter wraps, then a short wrapped gap
    offer(16'h8000, 1'b1, 32'hFFFF_FFF0);
    offer(16'h0000, 1'b1, 32'h0000_0010);

    // zero hold time and a step far above the hold: saturates to zero
    set_meter(16'd0, 16'hFFFF);
    offer(16'h7FFF, 1'b1, 32'd20);
    offer(16'd300, 1'b1, 32'd20);
    // same stamp as the hold: zero hold time still keeps it
    offer(16'd200, 1'b1, 32'd20);
    offer(16'hFF38, 1'b1, 32'd21);

    // longest hold time, step of a full-scale peak
    set_meter(16'hFFFF, 16'h8000);
    offer(16'h8000, 1'b1, 32'd100);
    // block max equal to the level still decays it
    offer(16'h8000, 1'b1, 32'd100);
    offer(16'h0000, 1'b1, 32'd65635);
    offer(16'h0000, 1'b1, 32'd65636);

    // zero step: past the hold time the hold stays as it is
    set_meter(16'd5, 16'd0);
    offer(16'd1000, 1'b1, 32'd200);
    offer(16'h0000, 1'b1, 32'd300);

    // random blocks in three idling phases, two register settings each
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 55;
        end
        1: begin
          send_idle_pct = 55;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < 2; s++) begin
        set_meter(seg_hold[2 * p + s], seg_step[2 * p + s]);
        if (p == 2 && s == 0) begin
          // receiver holds off while a burst of one-sample blocks backs up
          // the pipe, then the sender waits for every reading
          long_stall_req = 1'b1;
          repeat (24) send_block(1);
          settle(0);
        end
        target = items_sent + RANDOM_ITEMS / 6;
        while (items_sent < target) begin
          send_block(($urandom_range(7) == 0) ? 1 : $urandom_range(2, 16));
        end
      end
    end

    settle(8);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
